@@ hw/rtl/crs_pkg.sv @@
// crs_pkg: shared types and constants of the connection rewire swap engine
// no dependencies; imported by connection_rewire_swap
package crs_pkg;

   localparam int SCORE_W     = 32;
   localparam int LIMIT_W     = 7;
   localparam int THRESHOLD_W = 16;
   localparam int INDEX_W     = 6;
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 16;
   localparam int PROD_W      = SCORE_W + THRESHOLD_W + 1;

   localparam logic [CSR_ADDR_W-1:0] CSR_SWAP_LIMIT     = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SWAP_THRESHOLD = 1'd1;

   localparam logic [LIMIT_W-1:0]     LIMIT_RESET     = 7'd1;
   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 16'd256;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_ROUND,
      ST_SCAN,
      ST_MUL,
      ST_CMP,
      ST_SWAP_ACT,
      ST_SWAP_SIL,
      ST_EMIT_RD,
      ST_EMIT_LD
   } state_type;

endpackage

@@ hw/rtl/crs_ram.sv @@
// crs_ram: generic single write port, single read port ram with registered read
// no dependencies; used for the score and active-bit stores
module crs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/connection_rewire_swap.sv @@
// connection_rewire_swap: top level of the rewire swap engine
// depends on crs_pkg and crs_ram (score store and active-bit store)
//
// Entries of a row are taken one per cycle and written to two on-chip rams.
// The item marked last starts the swap rounds, during which no item is taken.
// Each round spends a setup state, scans the n stored entries through the
// ram read port (one entry per cycle plus the read latency), then spends a
// state each on the multiply, the compare and the two bit writes. Results
// are then read back from the active-bit ram, each through a read state and
// a load state that waits for room in the output register, while the
// output register lets the next row start loading as soon as the last
// result of a row is held there.
module connection_rewire_swap
   import crs_pkg::*;
#(
   parameter int SOURCES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   // score [31:0], connected [32]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // index [5:0], new_connected [6], swaps_done [13:7]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = $clog2(SOURCES);
   localparam int CW = $clog2(SOURCES + 1);
   localparam logic [CW-1:0] SRC_CNT = CW'(SOURCES);

   state_type state_ff, state_in;

   logic [LIMIT_W-1:0]     limit_ff;
   logic [THRESHOLD_W-1:0] thr_ff;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] addr_ff, addr_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] pend_idx_ff, pend_idx_in;
   logic [LIMIT_W-1:0] swaps_ff, swaps_in;

   logic                      have_act_ff, have_act_in;
   logic                      have_sil_ff, have_sil_in;
   logic [AW-1:0]             act_id_ff, act_id_in;
   logic [AW-1:0]             sil_id_ff, sil_id_in;
   logic signed [SCORE_W-1:0] act_min_ff, act_min_in;
   logic signed [SCORE_W-1:0] sil_max_ff, sil_max_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [PROD_W-1:0]  lhs;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]   rsp_idx_ff, rsp_idx_in;
   logic                 rsp_conn_ff, rsp_conn_in;
   logic [LIMIT_W-1:0]   rsp_swaps_ff, rsp_swaps_in;
   logic                 rsp_final_ff, rsp_final_in;

   logic                      score_we;
   logic                      act_we;
   logic [AW-1:0]             act_waddr;
   logic                      act_wdata;
   logic [SCORE_W-1:0]        score_rdata;
   logic                      act_rdata;
   logic signed [SCORE_W-1:0] rd_score;
   logic                      req_accept;
   logic                      room;

   crs_ram #(.WIDTH(SCORE_W), .DEPTH(SOURCES)) u_score_ram (
      .clock (clock),
      .we    (score_we),
      .waddr (count_ff[AW-1:0]),
      .wdata (req_tdata[SCORE_W-1:0]),
      .raddr (addr_ff[AW-1:0]),
      .rdata (score_rdata)
   );

   crs_ram #(.WIDTH(1), .DEPTH(SOURCES)) u_active_ram (
      .clock (clock),
      .we    (act_we),
      .waddr (act_waddr),
      .wdata (act_wdata),
      .raddr (addr_ff[AW-1:0]),
      .rdata (act_rdata)
   );

   assign rd_score   = $signed(score_rdata);
   assign req_tready = (state_ff == ST_LOAD);
   assign req_accept = req_tvalid && req_tready;
   assign room       = (count_ff < SRC_CNT);
   assign score_we   = req_accept && room;
   assign lhs        = {{(PROD_W-SCORE_W-8){sil_max_ff[SCORE_W-1]}}, sil_max_ff, 8'd0};

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_final_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-INDEX_W-1-LIMIT_W){1'b0}}, rsp_swaps_ff, rsp_conn_ff,
                        rsp_idx_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         thr_ff   <= THRESHOLD_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_SWAP_LIMIT:     limit_ff <= csr_wdata[LIMIT_W-1:0];
            CSR_SWAP_THRESHOLD: thr_ff   <= csr_wdata[THRESHOLD_W-1:0];
            default:            ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      addr_ff      <= addr_in;
      pend_idx_ff  <= pend_idx_in;
      swaps_ff     <= swaps_in;
      have_act_ff  <= have_act_in;
      have_sil_ff  <= have_sil_in;
      act_id_ff    <= act_id_in;
      sil_id_ff    <= sil_id_in;
      act_min_ff   <= act_min_in;
      sil_max_ff   <= sil_max_in;
      prod_ff      <= prod_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_conn_ff  <= rsp_conn_in;
      rsp_swaps_ff <= rsp_swaps_in;
      rsp_final_ff <= rsp_final_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      n_in         = n_ff;
      addr_in      = addr_ff;
      pend_in      = 1'b0;
      pend_idx_in  = addr_ff[AW-1:0];
      swaps_in     = swaps_ff;
      have_act_in  = have_act_ff;
      have_sil_in  = have_sil_ff;
      act_id_in    = act_id_ff;
      sil_id_in    = sil_id_ff;
      act_min_in   = act_min_ff;
      sil_max_in   = sil_max_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_conn_in  = rsp_conn_ff;
      rsp_swaps_in = rsp_swaps_ff;
      rsp_final_in = rsp_final_ff;
      act_we       = 1'b0;
      act_waddr    = count_ff[AW-1:0];
      act_wdata    = req_tdata[SCORE_W];

      case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               act_we = room;
               if (room) begin
                  count_in = count_ff + 1'b1;
               end
               if (req_tlast) begin
                  n_in     = room ? count_ff + 1'b1 : count_ff;
                  swaps_in = '0;
                  state_in = ST_ROUND;
               end
            end
         end
         ST_ROUND: begin
            addr_in     = '0;
            have_act_in = 1'b0;
            have_sil_in = 1'b0;
            state_in    = (swaps_ff == limit_ff) ? ST_EMIT_RD : ST_SCAN;
         end
         ST_SCAN: begin
            if (pend_ff) begin
               if (act_rdata) begin
                  if (!have_act_ff || rd_score < act_min_ff) begin
                     have_act_in = 1'b1;
                     act_id_in   = pend_idx_ff;
                     act_min_in  = rd_score;
                  end
               end else begin
                  if (!have_sil_ff || rd_score > sil_max_ff) begin
                     have_sil_in = 1'b1;
                     sil_id_in   = pend_idx_ff;
                     sil_max_in  = rd_score;
                  end
               end
            end
            if (addr_ff != n_ff) begin
               pend_in = 1'b1;
               addr_in = addr_ff + 1'b1;
            end else if (!pend_ff) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in = $signed({1'b0, thr_ff}) * act_min_ff;
            addr_in = '0;
            if (!have_act_ff || !have_sil_ff) begin
               state_in = ST_EMIT_RD;
            end else begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = (lhs > prod_ff) ? ST_SWAP_ACT : ST_EMIT_RD;
         end
         ST_SWAP_ACT: begin
            act_we    = 1'b1;
            act_waddr = act_id_ff;
            act_wdata = 1'b0;
            state_in  = ST_SWAP_SIL;
         end
         ST_SWAP_SIL: begin
            act_we    = 1'b1;
            act_waddr = sil_id_ff;
            act_wdata = 1'b1;
            swaps_in  = swaps_ff + 1'b1;
            state_in  = ST_ROUND;
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = INDEX_W'(addr_ff);
               rsp_conn_in  = act_rdata;
               rsp_swaps_in = swaps_ff;
               rsp_final_in = (addr_ff + 1'b1 == n_ff);
               addr_in      = addr_ff + 1'b1;
               if (addr_ff + 1'b1 == n_ff) begin
                  count_in = '0;
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule
